/* sv/trimmed_mean_adc_filter_macros.svh */
// assertion macros shared by the trimmed mean filter modules
`ifndef TRIMMED_MEAN_ADC_FILTER_MACROS_SVH
`define TRIMMED_MEAN_ADC_FILTER_MACROS_SVH

// same-cycle implication under reset
`define TMAF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tmaf assertion failed");

// next-cycle implication under reset
`define TMAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tmaf assertion failed");

`endif

/* sv/tmaf_pkg.sv */
// shared constants, state encoding and control structs of the trimmed mean filter
package tmaf_pkg;

	localparam int CHANNELS    = 6;
	localparam int WINDOW      = 16;
	localparam int TRIM        = 3;
	localparam int SAMPLE_BITS = 12;
	localparam int ENABLE_BITS = 6;
	localparam int CH_BITS     = 3;
	localparam int KEPT        = WINDOW - 2 * TRIM;

	localparam int CH_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int FILL_BITS   = $clog2(WINDOW);
	localparam int ADDR_BITS   = $clog2(CHANNELS * WINDOW);
	localparam int ACC_BITS    = $clog2(WINDOW * ((1 << SAMPLE_BITS) - 1) + 1);
	localparam int KSUM_BITS   = $clog2(KEPT * ((1 << SAMPLE_BITS) - 1) + 1);
	localparam int REM_BITS    = $clog2(KEPT);

	// rounded-up reciprocal of the kept count, exact for every trimmed sum
	localparam int RECIP_SHIFT = KSUM_BITS + REM_BITS;
	localparam int RECIP       = ((1 << RECIP_SHIFT) + KEPT - 1) / KEPT;
	localparam int RECIP_BITS  = $clog2(RECIP + 1);
	localparam int PROD_BITS   = KSUM_BITS + RECIP_BITS;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_DRAIN,
		S_LOAD,
		S_DIV,
		S_HOLD
	} state_t;

	typedef struct packed {
		logic wr_en;
		logic start;
		logic rd_en;
		logic div_load;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic win_full;
		logic rd_last;
		logic out_free;
	} stat_t;

endpackage

/* sv/tmaf_ctrl.sv */
// controller state machine: sequences window read, trimming and division
`include "trimmed_mean_adc_filter_macros.svh"

module tmaf_ctrl
	import tmaf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall  = 1'b0;
				cmd.wr_en = in_valid;
				// last sample of a window starts the read sweep
				if (in_valid && stat.win_full) begin
					cmd.start = 1'b1;
					state_nxt = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				if (stat.rd_last) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_nxt = S_LOAD;
			end
			S_LOAD: begin
				cmd.div_load = 1'b1;
				state_nxt    = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				state_nxt    = S_HOLD;
			end
			S_HOLD: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	`TMAF_ASSERT_NEXT(a_start_reads, clk, arst_n, cmd.start, state_q == S_READ)
	`TMAF_ASSERT_NEXT(a_div_to_hold, clk, arst_n, state_q == S_DIV, state_q == S_HOLD)
	`TMAF_ASSERT_IMPLY(a_load_when_free, clk, arst_n, cmd.out_load, stat.out_free)

endmodule

/* sv/tmaf_datapath.sv */
// datapath: sample memory, fill counts, trim tracking, divider and output register
`include "trimmed_mean_adc_filter_macros.svh"

module tmaf_datapath
	import tmaf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [ENABLE_BITS-1:0] enable,
	input  logic [CH_BITS-1:0]     channel,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   out_stall,
	output logic                   out_valid,
	output logic [CH_BITS-1:0]     result_channel,
	output logic [SAMPLE_BITS-1:0] trimmed_average,
	input  cmd_t                   cmd,
	output stat_t                  stat
);

	logic [SAMPLE_BITS-1:0] mem_q [CHANNELS*WINDOW];
	logic [FILL_BITS-1:0]   fill_q [CHANNELS];

	logic [ENABLE_BITS-1:0] en_shift;
	logic                   channel_ok;
	logic [CH_IDX_BITS-1:0] ch_idx;
	logic [FILL_BITS-1:0]   fill_cur;
	logic                   win_full;
	logic [ADDR_BITS-1:0]   waddr;
	logic [ADDR_BITS-1:0]   raddr;

	logic [CH_IDX_BITS-1:0] ch_q;
	logic [FILL_BITS-1:0]   rd_idx_q;
	logic [SAMPLE_BITS-1:0] rd_data_s1;
	logic                   rd_vld_s1;

	logic [ACC_BITS-1:0]    acc_q;
	logic [SAMPLE_BITS-1:0] lo_q [TRIM];
	logic [SAMPLE_BITS-1:0] hi_q [TRIM];
	logic [SAMPLE_BITS-1:0] lo_nxt [TRIM];
	logic [SAMPLE_BITS-1:0] hi_nxt [TRIM];
	logic [TRIM-1:0]        lo_lt;
	logic [TRIM-1:0]        hi_gt;
	logic [ACC_BITS-1:0]    trim_sum;

	logic [KSUM_BITS-1:0]   dvd_q;
	logic [PROD_BITS-1:0]   prod;
	logic [SAMPLE_BITS-1:0] quot_q;

	logic                   out_valid_q;
	logic [CH_BITS-1:0]     result_channel_q;
	logic [SAMPLE_BITS-1:0] trimmed_average_q;

	// request decode: channels past the enable vector are always on
	assign en_shift   = enable >> channel;
	assign channel_ok = (32'(channel) < CHANNELS)
		&& ((32'(channel) >= ENABLE_BITS) || en_shift[0]);
	assign ch_idx     = CH_IDX_BITS'(channel);
	assign fill_cur   = fill_q[ch_idx];
	assign win_full   = channel_ok && (fill_cur == FILL_BITS'(WINDOW - 1));
	assign waddr      = ADDR_BITS'(32'(ch_idx) * WINDOW + 32'(fill_cur));
	assign raddr      = ADDR_BITS'(32'(ch_q) * WINDOW + 32'(rd_idx_q));

	always_ff @(posedge clk) begin
		if (cmd.wr_en && channel_ok) begin
			mem_q[waddr] <= sample;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				fill_q[i] <= '0;
			end
		end else if (cmd.wr_en && channel_ok) begin
			if (win_full) begin
				fill_q[ch_idx] <= '0;
			end else begin
				fill_q[ch_idx] <= fill_cur + FILL_BITS'(1);
			end
		end
	end

	// insertion into the running lists of smallest and largest values
	generate
		for (genvar j = 0; j < TRIM; j++) begin : g_trim
			assign lo_lt[j] = rd_data_s1 < lo_q[j];
			assign hi_gt[j] = rd_data_s1 > hi_q[j];
			if (j == 0) begin : g_first
				assign lo_nxt[j] = lo_lt[j] ? rd_data_s1 : lo_q[j];
				assign hi_nxt[j] = hi_gt[j] ? rd_data_s1 : hi_q[j];
			end else begin : g_rest
				assign lo_nxt[j] = !lo_lt[j] ? lo_q[j]
					: (lo_lt[j-1] ? lo_q[j-1] : rd_data_s1);
				assign hi_nxt[j] = !hi_gt[j] ? hi_q[j]
					: (hi_gt[j-1] ? hi_q[j-1] : rd_data_s1);
			end
		end
	endgenerate

	always_comb begin
		trim_sum = acc_q;
		for (int j = 0; j < TRIM; j++) begin
			trim_sum = trim_sum - ACC_BITS'(lo_q[j]) - ACC_BITS'(hi_q[j]);
		end
	end

	// division by the kept count: multiply by the reciprocal and shift
	assign prod = PROD_BITS'(dvd_q) * RECIP_BITS'(RECIP);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			ch_q  <= ch_idx;
			acc_q <= '0;
			for (int j = 0; j < TRIM; j++) begin
				lo_q[j] <= '1;
				hi_q[j] <= '0;
			end
		end else if (rd_vld_s1) begin
			acc_q <= acc_q + ACC_BITS'(rd_data_s1);
			lo_q  <= lo_nxt;
			hi_q  <= hi_nxt;
		end
		if (cmd.div_load) begin
			dvd_q <= KSUM_BITS'(trim_sum);
		end
		if (cmd.div_step) begin
			quot_q <= prod[RECIP_SHIFT +: SAMPLE_BITS];
		end
		if (cmd.out_load) begin
			result_channel_q  <= CH_BITS'(ch_q);
			trimmed_average_q <= quot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.start) begin
				rd_idx_q <= '0;
			end else if (cmd.rd_en) begin
				rd_idx_q <= rd_idx_q + FILL_BITS'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.win_full    = win_full;
	assign stat.rd_last     = rd_idx_q == FILL_BITS'(WINDOW - 1);
	assign stat.out_free    = !out_valid_q || !out_stall;

	assign out_valid       = out_valid_q;
	assign result_channel  = result_channel_q;
	assign trimmed_average = trimmed_average_q;

	`TMAF_ASSERT_NEXT(a_rd_pipe, clk, arst_n, cmd.rd_en, rd_vld_s1)
	`TMAF_ASSERT_IMPLY(a_start_on_full, clk, arst_n, cmd.start, cmd.wr_en && win_full)
	`TMAF_ASSERT_NEXT(a_out_loaded, clk, arst_n, cmd.out_load, out_valid_q)

endmodule

/* sv/trimmed_mean_adc_filter.sv */
// top level of the trimmed mean adc filter
//
// input channel: in_valid / in_stall carry one request of channel and sample.
// a sample for a disabled or nonexistent channel is dropped. each enabled
// channel fills its own window of 16 samples in the sample memory.
// most requests are taken without a stall; the request that completes a window holds
// in_stall high through a read sweep of all 16 samples of its window in the memory
// (one port read per cycle) with the three smallest and three largest values
// tracked on the fly, then a drain state, a state to latch the trimmed sum, a
// state to multiply it by the reciprocal of 10, and a state to move the result
// into the output register, after which out_valid rises for that request.
// a second finished window waits longer while the output is stalled.
// output channel: out_valid / out_stall carry result_channel and
// trimmed_average. a waiting result does not block new requests; only a
// second finished window waits in the holding state until the output frees.
// configuration: cfg_valid / cfg_ready write channel_enable, always ready,
// to be written only while the block is idle.
// reset clears all fill counts and the output valid, and enables all channels;
// the sample memory is not cleared, entries are read only after being written.
module trimmed_mean_adc_filter
	import tmaf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [CH_BITS-1:0]     channel,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [CH_BITS-1:0]     result_channel,
	output logic [SAMPLE_BITS-1:0] trimmed_average,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [ENABLE_BITS-1:0] channel_enable
);

	logic [ENABLE_BITS-1:0] enable_q;
	cmd_t                   cmd;
	stat_t                  stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			enable_q <= channel_enable;
		end
	end

	tmaf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	tmaf_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.enable          (enable_q),
		.channel         (channel),
		.sample          (sample),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.result_channel  (result_channel),
		.trimmed_average (trimmed_average),
		.cmd             (cmd),
		.stat            (stat)
	);

endmodule
